// File: rtl/efd_pkg.sv
package efd_pkg;

  localparam int unsigned WIN_LEN = 8;
  localparam int unsigned FILL_W = $clog2(WIN_LEN + 1);

  localparam logic [7:0] ESC_BYTE = 8'hDB;
  localparam logic [7:0] ESC_FLIP = 8'h20;

  // index 0 is the oldest byte of the window
  localparam logic [WIN_LEN-1:0][7:0] TERM_PAT = {
    8'hDB, 8'hDB, 8'hFB, 8'hFB, 8'hDB, 8'hDB, 8'hFF, 8'hDF
  };

  localparam logic [15:0] SILENCE_LIMIT_RESET = 16'd1000;
  localparam logic [15:0] SILENCE_MAX = 16'hFFFF;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef struct packed {
    op_t        opcode;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic       frame_end;
    logic       aborted;
  } result_t;

endpackage

// File: rtl/efd_core.sv
module efd_core import efd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  item_t       item,
  input  logic [15:0] silence_limit_ticks,
  output result_t     res
);

  logic [WIN_LEN-1:0][7:0] byte_window;
  logic [WIN_LEN-1:0][7:0] byte_window_next;
  logic [FILL_W-1:0]       window_fill;
  logic [FILL_W-1:0]       window_fill_next;
  logic                    escape_pending;
  logic                    escape_pending_next;
  logic                    in_frame;
  logic                    in_frame_next;
  logic [15:0]             silence_count;
  logic [15:0]             silence_count_next;

  logic [WIN_LEN-1:0][7:0] shifted;
  logic                    full;
  logic                    done;
  logic [7:0]              leaving;
  logic [15:0]             silence_inc;

  // the window shifts on every byte, full or not; only the fill count says how much of it is real
  assign shifted = {item.rx_byte, byte_window[WIN_LEN-1:1]};
  assign full    = (window_fill == FILL_W'(WIN_LEN));
  assign leaving = byte_window[0];
  assign done    = (full || window_fill == FILL_W'(WIN_LEN - 1)) && (shifted == TERM_PAT);
  assign silence_inc = (silence_count == SILENCE_MAX) ? silence_count
                                                      : silence_count + 16'd1;

  always_comb begin
    byte_window_next    = byte_window;
    window_fill_next    = window_fill;
    escape_pending_next = escape_pending;
    in_frame_next       = in_frame;
    silence_count_next  = silence_count;
    res                 = '0;
    if (item.opcode == OP_TICK) begin
      if (in_frame) begin
        if (silence_inc >= silence_limit_ticks) begin
          window_fill_next    = '0;
          escape_pending_next = 1'b0;
          in_frame_next       = 1'b0;
          silence_count_next  = '0;
          res.aborted         = 1'b1;
        end else begin
          silence_count_next = silence_inc;
        end
      end
    end else begin
      byte_window_next   = shifted;
      in_frame_next      = 1'b1;
      silence_count_next = '0;
      if (!full) begin
        window_fill_next = window_fill + FILL_W'(1);
      end
      if (full) begin
        if (escape_pending) begin
          res.payload_byte    = leaving ^ ESC_FLIP;
          res.payload_valid   = 1'b1;
          escape_pending_next = 1'b0;
        end else if (leaving == ESC_BYTE && !done) begin
          escape_pending_next = 1'b1;
        end else begin
          res.payload_byte  = leaving;
          res.payload_valid = 1'b1;
        end
      end
      if (done) begin
        res.frame_end       = 1'b1;
        window_fill_next    = '0;
        escape_pending_next = 1'b0;
        in_frame_next       = 1'b0;
        silence_count_next  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_fill    <= '0;
      escape_pending <= 1'b0;
      in_frame       <= 1'b0;
      silence_count  <= '0;
    end else if (accept) begin
      window_fill    <= window_fill_next;
      escape_pending <= escape_pending_next;
      in_frame       <= in_frame_next;
      silence_count  <= silence_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_window <= byte_window_next;
    end
  end

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    accept && res.frame_end |=> window_fill == '0 && !in_frame && !escape_pending)
    else $error("frame end did not clear the deframer state");

  a_abort_alone: assert property (@(posedge clk) disable iff (rst)
    res.aborted |-> !res.payload_valid && !res.frame_end && item.opcode == OP_TICK)
    else $error("abort combined with byte results");

  a_escape_in_frame: assert property (@(posedge clk) disable iff (rst)
    escape_pending |-> in_frame && window_fill == FILL_W'(WIN_LEN))
    else $error("escape pending outside a full frame window");

  a_silence_idle: assert property (@(posedge clk) disable iff (rst)
    !in_frame |-> silence_count == '0)
    else $error("silence count running outside a frame");

endmodule

// File: rtl/escaped_frame_deframer.sv
// Deframer for a byte-stuffed stream ended by the terminator DF FF DB DB FB FB DB DB.
// Every input transaction (a raw byte or a one-millisecond tick) gives exactly one result
// transaction, which is registered; a new transaction is taken every cycle while the skid register is empty.
// The result sits in an output register backed by a one-entry skid register, so input
// is stalled only when both hold results that have not been taken. Payload trails the
// input by eight bytes (the terminator window). silence_limit_ticks is written through
// the cfg channel, which is always ready; write it only while the deframer is idle.
module escaped_frame_deframer import efd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  item_t       item,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic [15:0] silence_limit_ticks;
  logic        accept;
  logic        out_take;
  logic        out_free;
  logic        skid_valid;
  result_t     skid;
  result_t     core_res;

  assign cfg_ready  = 1'b1;
  assign item_stall = skid_valid;
  assign accept     = item_valid && !item_stall;
  assign out_take   = result_valid && !result_stall;
  assign out_free   = !result_valid || out_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      silence_limit_ticks <= SILENCE_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      silence_limit_ticks <= cfg_data;
    end
  end

  efd_core u_core (
    .clk                 (clk),
    .rst                 (rst),
    .accept              (accept),
    .item                (item),
    .silence_limit_ticks (silence_limit_ticks),
    .res                 (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (out_free) begin
      result_valid <= skid_valid || accept;
      skid_valid   <= skid_valid && accept;
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        result <= skid;
        skid   <= core_res;
      end else begin
        result <= core_res;
      end
    end else if (accept) begin
      skid <= core_res;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid register holds a result ahead of the output register");

  a_stall_fills_skid: assert property (@(posedge clk) disable iff (rst)
    accept && result_valid && result_stall |=> skid_valid && result_valid)
    else $error("transaction taken under output stall was lost");

endmodule

// File: tb/sv/tb_escaped_frame_deframer.sv
`timescale 1ns / 1ps

module tb_escaped_frame_deframer;
  import efd_pkg::*;

  logic        clk = 1'b0;
  logic        rst;
  logic        item_valid;
  logic        item_stall;
  item_t       item;
  logic        result_valid;
  logic        result_stall;
  result_t     result;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  escaped_frame_deframer DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always #10 clk = ~clk;

  // deframer state as predicted
  logic [WIN_LEN-1:0][7:0] win_bytes;
  int unsigned             win_fill;
  bit                      escape_held;
  bit                      frame_open;
  logic [15:0]             silence_ticks;
  logic [15:0]             silence_limit;

  result_t     expected_results[$];
  int unsigned idle_max = 5;
  int unsigned items_sent = 0;
  int unsigned stall_left = 0;
  bit          sink_hold = 1'b0;
  int          errors = 0;

  function automatic void clear_frame_state();
    win_bytes = '0;
    win_fill = 0;
    escape_held = 1'b0;
    frame_open = 1'b0;
    silence_ticks = '0;
  endfunction

  function automatic result_t deframe_predict(item_t it);
    result_t    r;
    logic [7:0] leaving;
    bit         left;
    bit         done;
    r = '0;
    leaving = '0;
    left = 1'b0;
    if (it.opcode == OP_TICK) begin
      if (frame_open) begin
        if (silence_ticks != SILENCE_MAX) silence_ticks++;
        if (silence_ticks >= silence_limit) begin
          clear_frame_state();
          r.aborted = 1'b1;
        end
      end
    end else begin
      frame_open = 1'b1;
      silence_ticks = '0;
      if (win_fill >= WIN_LEN) begin
        leaving = win_bytes[0];
        left = 1'b1;
        win_bytes = {it.rx_byte, win_bytes[WIN_LEN-1:1]};
      end else begin
        win_bytes[win_fill] = it.rx_byte;
        win_fill++;
      end
      done = (win_fill == WIN_LEN) && (win_bytes == TERM_PAT);
      if (left) begin
        if (escape_held) begin
          r.payload_byte = leaving ^ ESC_FLIP;
          r.payload_valid = 1'b1;
          escape_held = 1'b0;
        end else if (leaving == ESC_BYTE && !done) begin
          escape_held = 1'b1;
        end else begin
          r.payload_byte = leaving;
          r.payload_valid = 1'b1;
        end
      end
      if (done) begin
        r.frame_end = 1'b1;
        clear_frame_state();
      end
    end
    return r;
  endfunction

  task automatic check_result(input result_t got);
    result_t want;
    if (expected_results.size() == 0) begin
      $error("result transaction with nothing expected: %h", got);
      errors++;
      return;
    end
    want = expected_results.pop_front();
    if (got.payload_byte !== want.payload_byte) begin
      $error("payload_byte: expected %h, actual %h", want.payload_byte, got.payload_byte);
      errors++;
    end
    if (got.payload_valid !== want.payload_valid) begin
      $error("payload_valid: expected %b, actual %b", want.payload_valid, got.payload_valid);
      errors++;
    end
    if (got.frame_end !== want.frame_end) begin
      $error("frame_end: expected %b, actual %b", want.frame_end, got.frame_end);
      errors++;
    end
    if (got.aborted !== want.aborted) begin
      $error("aborted: expected %b, actual %b", want.aborted, got.aborted);
      errors++;
    end
  endtask

  // result side: check each transaction, then stall at random
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      check_result(result);
      stall_left = $urandom_range(0, idle_max);
    end
    if (stall_left > 0) begin
      result_stall <= 1'b1;
      stall_left--;
    end else begin
      result_stall <= sink_hold;
    end
  end

  task automatic send_item(input op_t op, input logic [7:0] b);
    item_t       it;
    int unsigned gap;
    it.opcode = op;
    it.rx_byte = b;
    gap = $urandom_range(0, idle_max);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    expected_results = {expected_results, deframe_predict(it)};
    items_sent++;
    do @(posedge clk); while (item_stall);
  endtask

  task automatic send_ticks(input int unsigned n);
    repeat (n) send_item(OP_TICK, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_terminator(input int unsigned n);
    for (int i = 0; i < n; i++) send_item(OP_BYTE, TERM_PAT[i]);
  endtask

  // biased toward the bytes the terminator is made of
  function automatic logic [7:0] random_byte();
    if ($urandom_range(0, 2) == 0) return TERM_PAT[$urandom_range(0, WIN_LEN - 1)];
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic wait_idle();
    item_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_limit(input logic [15:0] v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    silence_limit = v;
  endtask

  // stuffed payload, then a whole or cut terminator, sometimes silence after it
  task automatic send_frame();
    int unsigned len;
    logic [7:0]  b;
    len = $urandom_range(0, 12);
    repeat (len) begin
      b = random_byte();
      if (b == ESC_BYTE || $urandom_range(0, 5) == 0) begin
        send_item(OP_BYTE, ESC_BYTE);
        send_item(OP_BYTE, b ^ ESC_FLIP);
      end else begin
        send_item(OP_BYTE, b);
      end
      if (silence_limit > 1 && $urandom_range(0, 7) == 0)
        send_ticks($urandom_range(1, silence_limit - 1));
    end
    if ($urandom_range(0, 5) == 0) send_terminator($urandom_range(1, WIN_LEN - 1));
    else send_terminator(WIN_LEN);
    if ($urandom_range(0, 3) == 0) send_ticks($urandom_range(0, silence_limit + 2));
  endtask

  task automatic send_noise(input int unsigned n);
    repeat (n) begin
      if ($urandom_range(0, 3) == 0) send_ticks(1);
      else send_item(OP_BYTE, random_byte());
    end
  endtask

  task automatic test_default_silence();
    send_ticks(2);
    send_item(OP_BYTE, 8'h5A);
    // ticks well below the reset limit leave the frame open
    send_ticks(40);
    send_item(OP_BYTE, 8'hA5);
    send_ticks(40);
  endtask

  task automatic test_directed();
    write_limit(16'd1);
    send_ticks(1);
    send_terminator(WIN_LEN);
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_BYTE, ESC_BYTE);
    send_item(OP_BYTE, 8'hFB);
    send_item(OP_BYTE, 8'h00);
    // escape byte as last payload byte comes out unchanged
    send_item(OP_BYTE, ESC_BYTE);
    send_terminator(WIN_LEN);
    send_item(OP_BYTE, 8'h80);
    send_ticks(1);
  endtask

  task automatic test_limit_extremes();
    write_limit(16'd0);
    send_item(OP_BYTE, 8'h3C);
    send_ticks(2);
    write_limit(SILENCE_MAX);
    idle_max = 0;
    send_item(OP_BYTE, 8'hC3);
    send_ticks(40);
    idle_max = 5;
  endtask

  task automatic test_backpressure();
    write_limit(16'd20);
    idle_max = 0;
    fork
      begin
        sink_hold <= 1'b1;
        repeat (40) @(posedge clk);
        sink_hold <= 1'b0;
      end
      begin
        repeat (30) send_item(OP_BYTE, random_byte());
        send_terminator(WIN_LEN);
      end
    join
    idle_max = 5;
  endtask

  task automatic test_random_traffic(input int unsigned count);
    int unsigned stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      // write_limit drains first, so the sender pauses here
      write_limit($urandom_range(1, 30));
      idle_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
      repeat (6) begin
        if ($urandom_range(0, 4) == 0) send_noise($urandom_range(1, 10));
        else send_frame();
      end
    end
    idle_max = 5;
  endtask

  initial begin
    rst <= 1'b1;
    item_valid <= 1'b0;
    item <= '0;
    result_stall <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    silence_limit = SILENCE_LIMIT_RESET;
    clear_frame_state();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_default_silence();
    test_directed();
    test_limit_extremes();
    test_backpressure();
    test_random_traffic(380);
    wait_idle();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// File: filelist.f
rtl/efd_pkg.sv
rtl/efd_core.sv
rtl/escaped_frame_deframer.sv
tb/sv/tb_escaped_frame_deframer.sv
